>>> sv/cwfd_pkg.sv
// Shared types, constants and the CRC-8 byte function of the word-frame deframer.
package cwfd_pkg;

    localparam logic [7:0] CRC_INIT = 8'hFF;
    localparam logic [7:0] CRC_POLY = 8'h31;
    localparam logic [7:0] CRC_TOP  = 8'h80;

    // Frame layout: six words, each high byte, low byte, CRC byte (18 beats).
    localparam logic [2:0] LAST_WORD   = 3'd5;
    localparam logic [1:0] OFFSET_HIGH = 2'd0;
    localparam logic [1:0] OFFSET_LOW  = 2'd1;
    localparam logic [1:0] OFFSET_CRC  = 2'd2;

    typedef logic [2:0] t_word_idx;
    typedef logic [1:0] t_offset;

    // One finished frame, as handed from the controller to the output stage.
    typedef struct packed {
        logic [31:0] co2_bits;
        logic [31:0] temperature_bits;
        logic [31:0] humidity_bits;
        logic        frame_ok;
    } t_result;

    // CRC-8, MSB first, no reflection, no final xor; eight bit steps unrolled.
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            if ((c & CRC_TOP) != 8'h00) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

>>> sv/crc_checked_word_frame_deframer_core.sv
// Top level of the CRC-checked word-frame deframer.
//
// Input channel: one received byte per beat (i_in_valid / o_in_stall), with
// i_frame_start marking byte 0 of a new 18-byte frame. Each frame is six words
// of high byte, low byte and CRC-8 (poly 0x31, init 0xFF).
// Output channel (o_out_valid / i_out_stall): one beat per complete frame,
// carrying the three 32-bit words and o_frame_ok, set only if all six CRCs
// matched. Bad frames are still delivered, with o_frame_ok low.
// Throughput: one input byte per cycle, except while o_in_stall holds a byte off. The result
// appears in the cycle after the 18th byte is accepted, from the output register.
// The output register decouples the sides: bytes keep flowing while a result
// waits. Only the closing byte of the next frame is held off (o_in_stall)
// while an earlier result is still stalled by the receiver.
// Reset (i_rst_n, synchronous, active low) returns the count to byte 0,
// the CRC to 0xFF and empties the output register.
module crc_checked_word_frame_deframer_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_frame_start,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_co2_bits,
    output logic [31:0] o_temperature_bits,
    output logic [31:0] o_humidity_bits,
    output logic        o_frame_ok
);

    logic              beat;
    logic              done;
    logic              out_blocked;
    logic              last_pending;
    cwfd_pkg::t_result frame_result;
    cwfd_pkg::t_result out_result;

    // Hold off any beat that could complete a frame while the output is full
    assign out_blocked = o_out_valid && i_out_stall;
    assign o_in_stall  = out_blocked && last_pending;
    assign beat        = i_in_valid && !o_in_stall;

    cwfd_frame_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_beat        (beat),
        .i_rx_byte     (i_rx_byte),
        .i_frame_start (i_frame_start),
        .o_done        (done),
        .o_result      (frame_result)
    );

    // Track whether the next byte is the closing CRC byte of a frame
    logic [4:0] r_count;
    logic [4:0] n_count;

    always_comb begin
        n_count = i_frame_start ? 5'd1 : r_count + 5'd1;
        if (done) begin
            n_count = 5'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 5'd0;
        end else if (beat) begin
            r_count <= n_count;
        end
    end

    assign last_pending = (r_count == 5'd17);

    cwfd_out_stage u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (done),
        .i_result (frame_result),
        .i_stall  (i_out_stall),
        .o_valid  (o_out_valid),
        .o_result (out_result)
    );

    assign o_co2_bits         = out_result.co2_bits;
    assign o_temperature_bits = out_result.temperature_bits;
    assign o_humidity_bits    = out_result.humidity_bits;
    assign o_frame_ok         = out_result.frame_ok;

endmodule

>>> sv/cwfd_frame_ctrl.sv
// Frame position tracking, per-word CRC check and data byte capture.
module cwfd_frame_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_beat,
    input  logic [7:0]         i_rx_byte,
    input  logic               i_frame_start,
    output logic               o_done,
    output cwfd_pkg::t_result  o_result
);

    cwfd_pkg::t_word_idx r_word, n_word;
    cwfd_pkg::t_offset   r_offset, n_offset;
    logic [7:0]          r_crc, n_crc;
    logic                r_mismatch, n_mismatch;
    logic [31:0]         r_words [3];

    // Effective position, crc and flag once a frame start is applied
    cwfd_pkg::t_word_idx eff_word;
    cwfd_pkg::t_offset   eff_offset;
    logic [7:0]          eff_crc;
    logic                eff_mismatch;
    logic                is_data;
    logic                is_last;
    logic [1:0]          slot;
    logic [1:0]          lane;

    always_comb begin
        eff_word     = i_frame_start ? '0 : r_word;
        eff_offset   = i_frame_start ? cwfd_pkg::OFFSET_HIGH : r_offset;
        eff_crc      = i_frame_start ? cwfd_pkg::CRC_INIT : r_crc;
        eff_mismatch = i_frame_start ? 1'b0 : r_mismatch;
        is_data      = (eff_offset != cwfd_pkg::OFFSET_CRC);
        is_last      = (eff_word == cwfd_pkg::LAST_WORD) && !is_data;
        // even words go to the upper half, high bytes to the upper lane
        slot         = eff_word[2:1];
        lane         = {~eff_word[0], (eff_offset == cwfd_pkg::OFFSET_HIGH)};
    end

    // Next state for the position, CRC and mismatch flag
    always_comb begin
        n_word     = eff_word;
        n_offset   = eff_offset;
        n_crc      = eff_crc;
        n_mismatch = eff_mismatch;
        case (eff_offset)
            cwfd_pkg::OFFSET_HIGH: begin
                n_crc    = cwfd_pkg::crc8_byte(eff_crc, i_rx_byte);
                n_offset = cwfd_pkg::OFFSET_LOW;
            end
            cwfd_pkg::OFFSET_LOW: begin
                n_crc    = cwfd_pkg::crc8_byte(eff_crc, i_rx_byte);
                n_offset = cwfd_pkg::OFFSET_CRC;
            end
            default: begin
                n_crc      = cwfd_pkg::CRC_INIT;
                n_offset   = cwfd_pkg::OFFSET_HIGH;
                n_mismatch = eff_mismatch | (eff_crc != i_rx_byte);
                n_word     = eff_word + 3'd1;
                if (is_last) begin
                    n_word     = '0;
                    n_mismatch = 1'b0;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word     <= '0;
            r_offset   <= cwfd_pkg::OFFSET_HIGH;
            r_crc      <= cwfd_pkg::CRC_INIT;
            r_mismatch <= 1'b0;
        end else if (i_beat) begin
            r_word     <= n_word;
            r_offset   <= n_offset;
            r_crc      <= n_crc;
            r_mismatch <= n_mismatch;
        end
    end

    // Data byte capture; every byte is written before the frame end reads it
    always_ff @(posedge i_clk) begin
        if (i_beat && is_data) begin
            r_words[slot][lane*8 +: 8] <= i_rx_byte;
        end
    end

    // Result is complete on the CRC beat of the last word
    assign o_done                     = i_beat && is_last;
    assign o_result.co2_bits          = r_words[0];
    assign o_result.temperature_bits  = r_words[1];
    assign o_result.humidity_bits     = r_words[2];
    assign o_result.frame_ok          = !(eff_mismatch || (eff_crc != i_rx_byte));

endmodule

>>> sv/cwfd_out_stage.sv
// Output register holding one finished frame until the receiver takes it.
module cwfd_out_stage (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  cwfd_pkg::t_result  i_result,
    input  logic               i_stall,
    output logic               o_valid,
    output cwfd_pkg::t_result  o_result
);

    logic              r_valid;
    cwfd_pkg::t_result r_result;

    // Valid flag: set on load, cleared once the beat is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

>>> sim/crc_checked_word_frame_deframer_core_tb.sv
// Self-checking testbench for the CRC-checked word-frame deframer core.
module crc_checked_word_frame_deframer_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAME_BEATS  = 18;
    localparam int PHASE_BEATS  = 370;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 10;
    localparam int CYCLE_LIMIT  = 200000;

    // Phases of the random part: how both sides idle
    typedef enum int {
        PH_NO_IDLE,
        PH_SENDER_IDLE,
        PH_RECEIVER_STALL,
        PH_BOTH_IDLE,
        PH_HOLD_OFF
    } t_phase;

    // Frame decoder mirror: byte count, running CRC, captured words and the queue
    // of finished frames still to come out of the block
    class frame_scoreboard;
        bit [4:0]          byte_pos;
        bit [7:0]          word_crc;
        bit [31:0]         words [3];
        bit                crc_bad;
        cwfd_pkg::t_result frames_due [$];
        int                errors;

        function new();
            byte_pos = '0;
            word_crc = cwfd_pkg::CRC_INIT;
            crc_bad  = 1'b0;
            errors   = 0;
            foreach (words[i]) words[i] = '0;
        endfunction

        // CRC-8 of one byte, bit by bit from the top, feedback into poly 0x31
        static function bit [7:0] crc_step(bit [7:0] crc, bit [7:0] b);
            bit [7:0] acc;
            bit       fb;
            acc = crc;
            for (int i = 7; i >= 0; i--) begin
                fb  = acc[7] ^ b[i];
                acc = {acc[6:0], 1'b0};
                if (fb) begin
                    acc = acc ^ cwfd_pkg::CRC_POLY;
                end
            end
            return acc;
        endfunction

        // One accepted input beat
        function void note_byte(bit [7:0] b, bit start);
            int                pos;
            int                word;
            int                offset;
            int                shift;
            cwfd_pkg::t_result res;
            if (start) begin
                byte_pos = '0;
                word_crc = cwfd_pkg::CRC_INIT;
                crc_bad  = 1'b0;
            end
            pos = (byte_pos >= FRAME_BEATS) ? 0 : int'(byte_pos);
            word   = pos / 3;
            offset = pos % 3;
            if (offset != int'(cwfd_pkg::OFFSET_CRC)) begin
                // even word to the upper half, high byte to the upper byte
                shift = ((word % 2) == 1 ? 0 : 16)
                        + (offset == int'(cwfd_pkg::OFFSET_HIGH) ? 8 : 0);
                words[word / 2][shift +: 8] = b;
                word_crc = crc_step(word_crc, b);
            end else begin
                if (word_crc != b) begin
                    crc_bad = 1'b1;
                end
                word_crc = cwfd_pkg::CRC_INIT;
            end
            if (pos == FRAME_BEATS - 1) begin
                res.co2_bits         = words[0];
                res.temperature_bits = words[1];
                res.humidity_bits    = words[2];
                res.frame_ok         = !crc_bad;
                frames_due.push_back(res);
                byte_pos = '0;
                word_crc = cwfd_pkg::CRC_INIT;
                crc_bad  = 1'b0;
            end else begin
                byte_pos = 5'(pos + 1);
            end
        endfunction

        task report(string what);
            $display("[%0t] mismatch: %s", $realtime, what);
            errors++;
        endtask

        // One accepted output beat against the oldest finished frame
        task check_frame(cwfd_pkg::t_result got);
            cwfd_pkg::t_result exp_frame;
            if (frames_due.size() == 0) begin
                report($sformatf("unexpected result co2=%h temp=%h hum=%h ok=%b",
                                 got.co2_bits, got.temperature_bits,
                                 got.humidity_bits, got.frame_ok));
                return;
            end
            exp_frame = frames_due.pop_front();
            if (got.co2_bits != exp_frame.co2_bits) begin
                report($sformatf("co2_bits %h, want %h", got.co2_bits, exp_frame.co2_bits));
            end
            if (got.temperature_bits != exp_frame.temperature_bits) begin
                report($sformatf("temperature_bits %h, want %h",
                                 got.temperature_bits, exp_frame.temperature_bits));
            end
            if (got.humidity_bits != exp_frame.humidity_bits) begin
                report($sformatf("humidity_bits %h, want %h",
                                 got.humidity_bits, exp_frame.humidity_bits));
            end
            if (got.frame_ok != exp_frame.frame_ok) begin
                report($sformatf("frame_ok %b, want %b", got.frame_ok, exp_frame.frame_ok));
            end
        endtask

        function int outstanding();
            return frames_due.size();
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [7:0]  i_rx_byte;
    logic        i_frame_start;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [31:0] o_co2_bits;
    logic [31:0] o_temperature_bits;
    logic [31:0] o_humidity_bits;
    logic        o_frame_ok;

    frame_scoreboard sb = new();
    int send_idle_pct = 0;
    int stall_pct     = 0;
    int hold_left     = 0;
    int beats_sent    = 0;
    int cycle_count   = 0;

    crc_checked_word_frame_deframer_core dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_rx_byte          (i_rx_byte),
        .i_frame_start      (i_frame_start),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_co2_bits         (o_co2_bits),
        .o_temperature_bits (o_temperature_bits),
        .o_humidity_bits    (o_humidity_bits),
        .o_frame_ok         (o_frame_ok)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Receiver: long hold-off when asked, otherwise random stalls
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            i_out_stall <= 1'b1;
            hold_left--;
        end else begin
            i_out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // Output monitor
    always @(posedge i_clk) begin
        cwfd_pkg::t_result got;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got.co2_bits         = o_co2_bits;
            got.temperature_bits = o_temperature_bits;
            got.humidity_bits    = o_humidity_bits;
            got.frame_ok         = o_frame_ok;
            sb.check_frame(got);
        end
    end

    // Watchdog
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("FAILURE");
        $finish;
    end

    // One beat on the input; entered and left at a falling edge
    task send_byte(bit [7:0] b, bit start);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid    <= 1'b0;
            i_rx_byte     <= 8'($urandom);
            i_frame_start <= 1'($urandom);
            @(negedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_rx_byte     <= b;
        i_frame_start <= start;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        sb.note_byte(b, start);
        beats_sent++;
        @(negedge i_clk);
    endtask

    // Data byte, weighted towards the extremes
    function automatic bit [7:0] pick_byte(int fill);
        int r;
        if (fill >= 0) begin
            return 8'(fill);
        end
        r = $urandom_range(9);
        if (r == 0) begin
            return 8'h00;
        end else if (r == 1) begin
            return 8'hFF;
        end
        return 8'($urandom);
    endfunction

    // Whole or truncated frame; corrupt spoils one CRC, sometimes more
    task send_frame(bit start, bit corrupt, int len, int fill);
        bit [7:0] frame_bytes [FRAME_BEATS];
        bit [7:0] hi;
        bit [7:0] lo;
        bit [7:0] crc;
        int       bad_word;
        bad_word = corrupt ? int'($urandom_range(5)) : -1;
        for (int w = 0; w < FRAME_BEATS / 3; w++) begin
            hi  = pick_byte(fill);
            lo  = pick_byte(fill);
            crc = frame_scoreboard::crc_step(
                      frame_scoreboard::crc_step(cwfd_pkg::CRC_INIT, hi), lo);
            if (w == bad_word || (corrupt && $urandom_range(3) == 0)) begin
                crc = crc ^ (8'h01 << $urandom_range(7));
            end
            frame_bytes[3 * w]     = hi;
            frame_bytes[3 * w + 1] = lo;
            frame_bytes[3 * w + 2] = crc;
        end
        for (int i = 0; i < len; i++) begin
            send_byte(frame_bytes[i], start && i == 0);
        end
    endtask

    // Random traffic: mostly clean frames, some bad CRCs, cut frames and noise
    task send_random_traffic(int beats);
        int  stop_at;
        int  r;
        bit  need_start;
        stop_at    = beats_sent + beats;
        need_start = 1'b1;
        while (beats_sent < stop_at) begin
            r = $urandom_range(99);
            if (r < 70) begin
                send_frame(need_start || $urandom_range(1), 1'b0, FRAME_BEATS, -1);
                need_start = 1'b0;
            end else if (r < 85) begin
                send_frame(need_start || $urandom_range(1), 1'b1, FRAME_BEATS, -1);
                need_start = 1'b0;
            end else if (r < 95) begin
                send_frame(1'b1, 1'($urandom), $urandom_range(1, FRAME_BEATS - 1), -1);
                need_start = 1'b1;
            end else begin
                repeat ($urandom_range(1, 6)) begin
                    send_byte(8'($urandom), 1'($urandom));
                end
                need_start = 1'b1;
            end
        end
    endtask

    task wait_idle();
        while (sb.outstanding() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    initial begin
        t_phase ph;
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_rx_byte     = 8'h00;
        i_frame_start = 1'b0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: start on byte 0 of a cut frame of zeros, then a restart
        // mid-frame into an all-ones frame with a bad CRC
        send_frame(1'b1, 1'b0, 4, 8'h00);
        send_frame(1'b1, 1'b1, FRAME_BEATS, 8'hFF);
        i_in_valid <= 1'b0;
        wait_idle();

        ph = PH_NO_IDLE;
        repeat (5) begin
            case (ph)
                PH_NO_IDLE: begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                end
                PH_SENDER_IDLE: begin
                    send_idle_pct = 72;
                    stall_pct     = 0;
                end
                PH_RECEIVER_STALL: begin
                    send_idle_pct = 0;
                    stall_pct     = 72;
                end
                PH_BOTH_IDLE: begin
                    send_idle_pct = 37;
                    stall_pct     = 37;
                end
                default: begin
                    // receiver holds off while bytes keep coming, filling the block
                    send_idle_pct = 0;
                    stall_pct     = 0;
                    hold_left     = HOLD_CYCLES;
                end
            endcase
            send_random_traffic(PHASE_BEATS);
            ph = ph.next();
        end

        i_in_valid    <= 1'b0;
        send_idle_pct = 0;
        stall_pct     = 0;
        wait_idle();

        if (sb.errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

>>> crc_checked_word_frame_deframer_core.f
sv/cwfd_pkg.sv
sv/cwfd_frame_ctrl.sv
sv/cwfd_out_stage.sv
sv/crc_checked_word_frame_deframer_core.sv
sim/crc_checked_word_frame_deframer_core_tb.sv
